// File: rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion helpers shared by the key debouncer modules.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define ASSERT_ALWAYS(label, clk, rst_n, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("assertion failed");

`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`else

`define ASSERT_ALWAYS(label, clk, rst_n, expr)

`define ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

// File: rtl/kdb_pkg.sv
// ----------------------------------------------------------------------------
// kdb_pkg
// Types and constants of the key debouncer with press, release and hold events.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package kdb_pkg;

    localparam int CFG_INDEX_W = 4;
    localparam int CFG_DATA_W  = 16;
    localparam int DEB_W       = 8;
    localparam int HOLD_W      = 16;
    localparam int KEY_W       = 8;
    localparam int KIND_W      = 2;

    localparam logic [CFG_INDEX_W-1:0] REG_ACTIVE_LEVEL   = 4'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_DEBOUNCE_TICKS = 4'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_HOLD_TICKS     = 4'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_KEY_NUMBER     = 4'd3;

    localparam logic              RST_ACTIVE_LEVEL   = 1'b1;
    localparam logic [DEB_W-1:0]  RST_DEBOUNCE_TICKS = 8'd2;
    localparam logic [HOLD_W-1:0] RST_HOLD_TICKS     = 16'd100;
    localparam logic [KEY_W-1:0]  RST_KEY_NUMBER     = 8'd0;

    localparam logic [HOLD_W-1:0] HOLD_MAX = {HOLD_W{1'b1}};

    typedef enum logic [1:0] {
        PHASE_WAIT_PRESS   = 2'd0,
        PHASE_DEBOUNCE     = 2'd1,
        PHASE_PRESSED      = 2'd2,
        PHASE_WAIT_RELEASE = 2'd3
    } phase_t;

    typedef enum logic [KIND_W-1:0] {
        KIND_PRESS   = 2'd0,
        KIND_RELEASE = 2'd1,
        KIND_HOLD    = 2'd2
    } kind_t;

    typedef struct packed {
        logic              active_level;
        logic [DEB_W-1:0]  debounce_ticks;
        logic [HOLD_W-1:0] hold_ticks;
        logic [KEY_W-1:0]  key_number;
    } cfg_t;

    typedef struct packed {
        logic  fire;
        kind_t kind;
    } step_t;

endpackage

`default_nettype wire

// File: rtl/kdb_pin_if.sv
// ----------------------------------------------------------------------------
// kdb_pin_if
// Stream of sampled key pin levels, one item per tick.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface kdb_pin_if;
    logic valid;
    logic ready;
    logic pin_level;

    modport source (output valid, output pin_level, input ready);
    modport sink (input valid, input pin_level, output ready);
endinterface

`default_nettype wire

// File: rtl/kdb_event_if.sv
// ----------------------------------------------------------------------------
// kdb_event_if
// Stream of key events, each carrying the key number and the event kind.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface kdb_event_if;
    logic                         valid;
    logic                         ready;
    logic [kdb_pkg::KEY_W-1:0]    event_key;
    logic [kdb_pkg::KIND_W-1:0]   event_kind;

    modport source (output valid, output event_key, output event_kind, input ready);
    modport sink (input valid, input event_key, input event_kind, output ready);
endinterface

`default_nettype wire

// File: rtl/key_debounce_press_release_hold.sv
// ----------------------------------------------------------------------------
// key_debounce_press_release_hold
// Key debouncer reporting press, release and long-press hold events; no release follows a hold.
// ----------------------------------------------------------------------------
// Usage: pin_in carries one item per tick holding the sampled pin level. Each
// accepted item advances the debounce and hold state machine by one tick and
// yields at most one event on evt_out, tagged with the configured key number.
// An event is registered in the output register, or in the skid register
// when the output register is held, as the item that caused it is accepted.
// One item is accepted in every cycle while the skid register is empty. The
// one-entry skid register lets an item still be accepted while one event
// waits to be taken; when the receiver stalls long enough for both to fill,
// pin_in drops ready until the output register drains. Configuration is
// written through cfg_we, cfg_index and cfg_data; the user must write it only
// while the block is idle, as the block does not enforce this. Unknown indices
// are ignored. Reset restores the default configuration, returns the key to
// the released phase and empties the output stage.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module key_debounce_press_release_hold (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    kdb_pin_if.sink                                 pin_in,
    kdb_event_if.source                             evt_out,
    input  wire logic                               cfg_we,
    input  wire logic [kdb_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  wire logic [kdb_pkg::CFG_DATA_W-1:0]     cfg_data
);

    kdb_pkg::cfg_t                  cfg_reg;
    kdb_pkg::step_t                 step;
    logic                           accept;
    logic                           push;
    logic                           pop;

    logic                           out_valid_reg;
    logic                           out_valid_next;
    logic [kdb_pkg::KEY_W-1:0]      out_key_reg;
    logic [kdb_pkg::KEY_W-1:0]      out_key_next;
    kdb_pkg::kind_t                 out_kind_reg;
    kdb_pkg::kind_t                 out_kind_next;
    logic                           skid_valid_reg;
    logic                           skid_valid_next;
    logic [kdb_pkg::KEY_W-1:0]      skid_key_reg;
    logic [kdb_pkg::KEY_W-1:0]      skid_key_next;
    kdb_pkg::kind_t                 skid_kind_reg;
    kdb_pkg::kind_t                 skid_kind_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.active_level   <= kdb_pkg::RST_ACTIVE_LEVEL;
            cfg_reg.debounce_ticks <= kdb_pkg::RST_DEBOUNCE_TICKS;
            cfg_reg.hold_ticks     <= kdb_pkg::RST_HOLD_TICKS;
            cfg_reg.key_number     <= kdb_pkg::RST_KEY_NUMBER;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                kdb_pkg::REG_ACTIVE_LEVEL:   cfg_reg.active_level   <= cfg_data[0];
                kdb_pkg::REG_DEBOUNCE_TICKS:
                    cfg_reg.debounce_ticks <= cfg_data[kdb_pkg::DEB_W-1:0];
                kdb_pkg::REG_HOLD_TICKS:
                    cfg_reg.hold_ticks     <= cfg_data[kdb_pkg::HOLD_W-1:0];
                kdb_pkg::REG_KEY_NUMBER:
                    cfg_reg.key_number     <= cfg_data[kdb_pkg::KEY_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    assign pin_in.ready = !skid_valid_reg;
    assign accept       = pin_in.valid && pin_in.ready;
    assign push         = accept && step.fire;
    assign pop          = out_valid_reg && evt_out.ready;

    kdb_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .step_en   (accept),
        .pin_level (pin_in.pin_level),
        .cfg       (cfg_reg),
        .step      (step)
    );

    always_comb
    begin
        out_valid_next  = out_valid_reg;
        out_key_next    = out_key_reg;
        out_kind_next   = out_kind_reg;
        skid_valid_next = skid_valid_reg;
        skid_key_next   = skid_key_reg;
        skid_kind_next  = skid_kind_reg;
        if (skid_valid_reg)
        begin
            if (pop)
            begin
                out_key_next    = skid_key_reg;
                out_kind_next   = skid_kind_reg;
                skid_valid_next = 1'b0;
            end
        end
        else if (push)
        begin
            if (!out_valid_reg || pop)
            begin
                out_valid_next = 1'b1;
                out_key_next   = cfg_reg.key_number;
                out_kind_next  = step.kind;
            end
            else
            begin
                skid_valid_next = 1'b1;
                skid_key_next   = cfg_reg.key_number;
                skid_kind_next  = step.kind;
            end
        end
        else if (pop)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_key_reg   <= out_key_next;
        out_kind_reg  <= out_kind_next;
        skid_key_reg  <= skid_key_next;
        skid_kind_reg <= skid_kind_next;
    end

    assign evt_out.valid      = out_valid_reg;
    assign evt_out.event_key  = out_key_reg;
    assign evt_out.event_kind = out_kind_reg;

    // The skid register only ever holds an item queued behind the output register.
    `ASSERT_ALWAYS(a_skid_behind_out, clk, rst_n, !skid_valid_reg || out_valid_reg)
    // Every item that yields an event leaves the output register occupied.
    `ASSERT_NEXT(a_push_lands, clk, rst_n, push, out_valid_reg)
    // The skid register fills only when the output register was stalled.
    `ASSERT_NEXT(a_skid_fill, clk, rst_n, !skid_valid_reg && !(out_valid_reg && !evt_out.ready),
        !skid_valid_reg)

endmodule

`default_nettype wire

// File: rtl/kdb_core.sv
// ----------------------------------------------------------------------------
// kdb_core
// Debounce and hold state machine; updates once for every accepted tick.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module kdb_core (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           step_en,
    input  wire logic           pin_level,
    input  wire kdb_pkg::cfg_t  cfg,
    output kdb_pkg::step_t      step
);

    kdb_pkg::phase_t                phase_reg;
    kdb_pkg::phase_t                phase_next;
    logic [kdb_pkg::DEB_W-1:0]      deb_count_reg;
    logic [kdb_pkg::DEB_W-1:0]      deb_count_next;
    logic [kdb_pkg::HOLD_W-1:0]     hold_count_reg;
    logic [kdb_pkg::HOLD_W-1:0]     hold_count_next;
    logic                           hold_fired_reg;
    logic                           hold_fired_next;

    logic                           active;
    logic [kdb_pkg::DEB_W-1:0]      deb_inc;
    logic                           deb_done;
    logic [kdb_pkg::HOLD_W-1:0]     hold_inc;
    logic                           hold_reached;

    assign active       = (pin_level == cfg.active_level);
    assign deb_inc      = deb_count_reg + kdb_pkg::DEB_W'(1);
    assign deb_done     = (deb_inc >= cfg.debounce_ticks) || (deb_inc == '0);
    assign hold_inc     = (hold_count_reg != kdb_pkg::HOLD_MAX)
                          ? hold_count_reg + kdb_pkg::HOLD_W'(1) : hold_count_reg;
    assign hold_reached = (hold_inc >= cfg.hold_ticks);

    always_comb
    begin
        phase_next      = phase_reg;
        deb_count_next  = deb_count_reg;
        hold_count_next = hold_count_reg;
        hold_fired_next = hold_fired_reg;
        case (phase_reg)
            kdb_pkg::PHASE_WAIT_PRESS:
            begin
                if (active)
                begin
                    phase_next = kdb_pkg::PHASE_DEBOUNCE;
                end
            end
            kdb_pkg::PHASE_DEBOUNCE:
            begin
                if (deb_done)
                begin
                    deb_count_next = '0;
                    phase_next     = active ? kdb_pkg::PHASE_PRESSED
                                            : kdb_pkg::PHASE_WAIT_PRESS;
                end
                else
                begin
                    deb_count_next = deb_inc;
                end
            end
            kdb_pkg::PHASE_PRESSED:
            begin
                phase_next = kdb_pkg::PHASE_WAIT_RELEASE;
            end
            kdb_pkg::PHASE_WAIT_RELEASE:
            begin
                if (!active)
                begin
                    phase_next      = kdb_pkg::PHASE_WAIT_PRESS;
                    hold_count_next = '0;
                    hold_fired_next = 1'b0;
                end
                else if (!hold_fired_reg)
                begin
                    hold_count_next = hold_inc;
                    hold_fired_next = hold_reached;
                end
            end
            default:
            begin
                phase_next = kdb_pkg::PHASE_WAIT_PRESS;
            end
        endcase
    end

    always_comb
    begin
        step.fire = 1'b0;
        step.kind = kdb_pkg::KIND_PRESS;
        case (phase_reg)
            kdb_pkg::PHASE_PRESSED:
            begin
                step.fire = 1'b1;
                step.kind = kdb_pkg::KIND_PRESS;
            end
            kdb_pkg::PHASE_WAIT_RELEASE:
            begin
                if (!active)
                begin
                    step.fire = !hold_fired_reg;
                    step.kind = kdb_pkg::KIND_RELEASE;
                end
                else
                begin
                    step.fire = !hold_fired_reg && hold_reached;
                    step.kind = kdb_pkg::KIND_HOLD;
                end
            end
            default:
            begin
                step.fire = 1'b0;
                step.kind = kdb_pkg::KIND_PRESS;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= kdb_pkg::PHASE_WAIT_PRESS;
            deb_count_reg  <= '0;
            hold_count_reg <= '0;
            hold_fired_reg <= 1'b0;
        end
        else if (step_en)
        begin
            phase_reg      <= phase_next;
            deb_count_reg  <= deb_count_next;
            hold_count_reg <= hold_count_next;
            hold_fired_reg <= hold_fired_next;
        end
    end

    // A fired hold belongs to a press that has not yet been released.
    `ASSERT_ALWAYS(a_fired_only_held, clk, rst_n,
        !hold_fired_reg || (phase_reg == kdb_pkg::PHASE_WAIT_RELEASE))
    // The debounce count is cleared whenever debouncing is left.
    `ASSERT_ALWAYS(a_deb_count_idle, clk, rst_n,
        (deb_count_reg == '0) || (phase_reg == kdb_pkg::PHASE_DEBOUNCE))
    // A confirmed press always leads to a press event on the next tick.
    `ASSERT_ALWAYS(a_press_fires, clk, rst_n,
        (phase_reg != kdb_pkg::PHASE_PRESSED) || (step.fire && (hold_count_reg == '0)))

endmodule

`default_nettype wire
